FILE: hdl/dsrq_pkg.sv
// ----------------------------------------------------------------------------
// dsrq_pkg
// shared types and constants of the deadline sorted ready queue
// ----------------------------------------------------------------------------
package dsrq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int TASK_W              = 8;
  localparam int DEADLINE_W          = 32;
  localparam int STATUS_W            = 2;
  localparam int OCC_W               = 5;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                  ins;
    logic                  ext;
    logic [TASK_W-1:0]     task_id;
    logic [DEADLINE_W-1:0] deadline;
  } cmd_t;

endpackage

FILE: hdl/dsrq_cell.sv
// ----------------------------------------------------------------------------
// dsrq_cell
// one slot of the sorted chain: keeps, shifts right on insert, shifts left
// on extract
// ----------------------------------------------------------------------------
module dsrq_cell
  import dsrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int IDX         = 0,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  logic [CW-1:0]         count,
  input  logic                  left_here,
  input  logic [DEADLINE_W-1:0] left_deadline,
  input  logic [TASK_W-1:0]     left_task,
  input  logic [DEADLINE_W-1:0] right_deadline,
  input  logic [TASK_W-1:0]     right_task,
  output logic                  here,
  output logic [DEADLINE_W-1:0] deadline,
  output logic [TASK_W-1:0]     task_id
);

  logic occupied;

  // new entry lands at or before this slot
  assign occupied = count > CW'(IDX);
  assign here     = !occupied || (cmd.deadline <= deadline);

  always_ff @(posedge clk) begin
    if (cmd.ins && here) begin
      if (left_here) begin
        deadline <= left_deadline;
        task_id  <= left_task;
      end else begin
        deadline <= cmd.deadline;
        task_id  <= cmd.task_id;
      end
    end else if (cmd.ext) begin
      deadline <= right_deadline;
      task_id  <= right_task;
    end
  end

endmodule

FILE: hdl/deadline_sorted_ready_queue.sv
// ----------------------------------------------------------------------------
// deadline_sorted_ready_queue
// earliest deadline first ready queue built as a chain of sorted cells
// ----------------------------------------------------------------------------
// Each beat on the slave side is an insert (task id and deadline) or an
// extract of the head task, and gives one result beat with the status, the
// removed task, the new running task and the occupancy. One beat is taken
// every cycle unless m_tready stalls the result: each cell compares the new
// deadline with its own entry in parallel and shifts in the same cycle, so
// the rate is set by that single compare and not by the queue depth. The
// result register lets a new beat in while the previous result is taken.
module deadline_sorted_ready_queue
  import dsrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // task_id[7:0], deadline[39:8]
  input  logic [0:0]  s_tuser,  // func[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // taken_task[7:0], taken_deadline[39:8],
                                // running_task[47:40], running_valid[48],
                                // occupancy[53:49], zero[55:54]
  output logic [1:0]  m_tuser   // status[1:0]
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                  accept;
  logic                  full;
  logic                  empty;
  cmd_t                  cmd;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [STATUS_W-1:0]   status_next;
  logic [TASK_W-1:0]     run_task_next;
  logic [CW+OCC_W-1:0]   count_ext;

  logic                  cell_here     [QUEUE_DEPTH];
  logic [DEADLINE_W-1:0] cell_deadline [QUEUE_DEPTH];
  logic [TASK_W-1:0]     cell_task     [QUEUE_DEPTH];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = count == CW'(QUEUE_DEPTH);
  assign empty    = count == '0;

  always_comb begin
    cmd.ins      = accept && (s_tuser[0] == FUNC_INSERT) && !full;
    cmd.ext      = accept && (s_tuser[0] == FUNC_EXTRACT) && !empty;
    cmd.task_id  = s_tdata[7:0];
    cmd.deadline = s_tdata[39:8];
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  lh;
    logic [DEADLINE_W-1:0] ld;
    logic [TASK_W-1:0]     lt;
    logic [DEADLINE_W-1:0] rd;
    logic [TASK_W-1:0]     rt;

    if (i == 0) begin : g_first
      assign lh = 1'b0;
      assign ld = '0;
      assign lt = '0;
    end else begin : g_mid
      assign lh = cell_here[i-1];
      assign ld = cell_deadline[i-1];
      assign lt = cell_task[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rd = cell_deadline[i];
      assign rt = cell_task[i];
    end else begin : g_inner
      assign rd = cell_deadline[i+1];
      assign rt = cell_task[i+1];
    end

    dsrq_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .count         (count),
      .left_here     (lh),
      .left_deadline (ld),
      .left_task     (lt),
      .right_deadline(rd),
      .right_task    (rt),
      .here          (cell_here[i]),
      .deadline      (cell_deadline[i]),
      .task_id       (cell_task[i])
    );
  end

  always_comb begin
    count_next    = count;
    status_next   = ST_OK;
    run_task_next = cell_task[0];
    if (cmd.ins) begin
      count_next = count + CW'(1);
      if (cell_here[0]) begin
        run_task_next = cmd.task_id;
      end
    end else if (cmd.ext) begin
      count_next    = count - CW'(1);
      run_task_next = cell_task[1];
    end else if (s_tuser[0] == FUNC_INSERT) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_EMPTY;
    end
    if (count_next == '0) begin
      run_task_next = '0;
    end
  end

  assign count_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser         <= status_next;
      m_tdata[7:0]    <= cmd.ext ? cell_task[0] : '0;
      m_tdata[39:8]   <= cmd.ext ? cell_deadline[0] : '0;
      m_tdata[47:40]  <= run_task_next;
      m_tdata[48]     <= count_next != '0;
      m_tdata[53:49]  <= count_ext[OCC_W-1:0];
      m_tdata[55:54]  <= '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0] == FUNC_INSERT && full) |=> count == $past(count))
    else $error("rejected insert changed the count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the queue");

  a_extract_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.ext |=> count == $past(count) - CW'(1))
    else $error("extract did not shrink the queue");

  a_running_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[48] == (count != '0))
    else $error("running flag disagrees with the count");

endmodule
